### design/boq_pkg.sv
// shared constants, codes and types of the branch order queue
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package boq_pkg;

   localparam int QUEUE_DEPTH = 8;
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
   localparam int TAG_W       = 10;
   localparam int PC_W        = 16;
   localparam int OP_W        = 2;
   localparam int STAT_W      = 2;
   localparam int OUT_CNT_W   = 4;

   localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
   localparam logic [OP_W-1:0] OP_RETIRE = 2'd1;
   localparam logic [OP_W-1:0] OP_FLUSH  = 2'd2;
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

   localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
   localparam logic [STAT_W-1:0] ST_FULL      = 2'd1;
   localparam logic [STAT_W-1:0] ST_MISMATCH  = 2'd2;
   localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd3;

   typedef struct packed {
      logic do_insert;
      logic do_pop;
      logic do_flush;
   } cell_ctrl_type;

endpackage

`default_nettype wire

### design/boq_cell.sv
// one queue slot: holds a tag and pc, shifts toward the head on retire
// depends on boq_pkg
`timescale 1ns / 1ps
`default_nettype none

module boq_cell
   import boq_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire cell_ctrl_type     ctrl,
   input  wire logic [TAG_W-1:0]  req_tag,
   input  wire logic [PC_W-1:0]   req_pc,
   input  wire logic              prev_valid,
   input  wire logic              next_valid,
   input  wire logic [TAG_W-1:0]  next_tag,
   input  wire logic [PC_W-1:0]   next_pc,
   input  wire logic              hit_in,
   output logic                   hit_out,
   output logic                   keep,
   output logic                   match,
   output logic                   valid,
   output logic [TAG_W-1:0]       tag,
   output logic [PC_W-1:0]        pc
);

   logic             valid_ff, valid_in;
   logic [TAG_W-1:0] tag_ff, tag_in;
   logic [PC_W-1:0]  pc_ff, pc_in;

   assign match   = valid_ff & (tag_ff == req_tag);
   assign hit_out = hit_in | match;
   assign keep    = valid_ff & (match | hit_in);
   assign valid   = valid_ff;
   assign tag     = tag_ff;
   assign pc      = pc_ff;

   always_comb begin
      valid_in = valid_ff;
      tag_in   = tag_ff;
      pc_in    = pc_ff;
      priority if (ctrl.do_insert) begin
         if (!valid_ff && prev_valid) begin
            valid_in = 1'b1;
            tag_in   = req_tag;
            pc_in    = req_pc;
         end
      end else if (ctrl.do_pop) begin
         valid_in = next_valid;
         tag_in   = next_tag;
         pc_in    = next_pc;
      end else if (ctrl.do_flush) begin
         valid_in = keep;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      tag_ff <= tag_in;
      pc_ff  <= pc_in;
   end

endmodule

`default_nettype wire

### design/branch_order_queue_core.sv
// program-ordered queue of in-flight branches built as a chain of boq_cell slots
// depends on boq_pkg and boq_cell
// the result is registered and strobed in the cycle after the transaction is taken
// throughput: one transaction per cycle, busy stays low; all slot tag compares run in
// parallel and the flush keep chain ripples combinationally across the cell row
// synchronous reset empties the queue and clears the newest tag; receiver cannot stall
`timescale 1ns / 1ps
`default_nettype none

module branch_order_queue_core
   import boq_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   output logic                       busy,
   input  wire logic [OP_W-1:0]       req_opcode,
   input  wire logic [TAG_W-1:0]      req_branch_tag,
   input  wire logic [PC_W-1:0]       req_branch_pc,
   input  wire logic                  req_is_control_flow,
   output logic                       rsp_valid,
   output logic [STAT_W-1:0]          rsp_status,
   output logic [OUT_CNT_W-1:0]       rsp_removed_count,
   output logic [PC_W-1:0]            rsp_retired_pc,
   output logic [OUT_CNT_W-1:0]       rsp_occupancy,
   output logic                       rsp_queue_full,
   output logic [TAG_W-1:0]           rsp_latest_tag
);

   cell_ctrl_type          ctrl;
   logic [QUEUE_DEPTH:0]   valid_pad;
   logic [QUEUE_DEPTH:0]   prev_pad;
   logic [QUEUE_DEPTH:0]   hit_pad;
   logic [TAG_W-1:0]       tag_pad [QUEUE_DEPTH+1];
   logic [PC_W-1:0]        pc_pad  [QUEUE_DEPTH+1];
   logic [QUEUE_DEPTH-1:0] keep_vec;
   logic [QUEUE_DEPTH-1:0] match_vec;

   logic [CNT_W-1:0]  count_ff, count_in;
   logic [TAG_W-1:0]  newest_ff, newest_in;
   logic [CNT_W-1:0]  flush_cnt;
   logic [CNT_W-1:0]  removed;
   logic [STAT_W-1:0] status;
   logic [PC_W-1:0]   retired_pc;
   logic              full;
   logic              head_hit;

   logic                 rsp_valid_ff;
   logic [STAT_W-1:0]    status_ff;
   logic [OUT_CNT_W-1:0] removed_ff;
   logic [PC_W-1:0]      retired_ff;
   logic [OUT_CNT_W-1:0] occ_ff;
   logic                 full_ff;
   logic [TAG_W-1:0]     latest_ff;

   assign busy = 1'b0;

   assign full     = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign head_hit = match_vec[0];
   assign flush_cnt = CNT_W'($countones(keep_vec));

   assign valid_pad[QUEUE_DEPTH] = 1'b0;
   assign tag_pad[QUEUE_DEPTH]   = '0;
   assign pc_pad[QUEUE_DEPTH]    = '0;
   assign hit_pad[QUEUE_DEPTH]   = 1'b0;
   assign prev_pad[0]            = 1'b1;

   always_comb begin
      ctrl.do_insert = start && (req_opcode == OP_INSERT) && !full;
      ctrl.do_pop    = start && (req_opcode == OP_RETIRE) && req_is_control_flow && head_hit;
      ctrl.do_flush  = start && (req_opcode == OP_FLUSH);
   end

   genvar gi;
   generate
      for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
         assign prev_pad[gi+1] = valid_pad[gi];
         boq_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .ctrl       (ctrl),
            .req_tag    (req_branch_tag),
            .req_pc     (req_branch_pc),
            .prev_valid (prev_pad[gi]),
            .next_valid (valid_pad[gi+1]),
            .next_tag   (tag_pad[gi+1]),
            .next_pc    (pc_pad[gi+1]),
            .hit_in     (hit_pad[gi+1]),
            .hit_out    (hit_pad[gi]),
            .keep       (keep_vec[gi]),
            .match      (match_vec[gi]),
            .valid      (valid_pad[gi]),
            .tag        (tag_pad[gi]),
            .pc         (pc_pad[gi])
         );
      end
   endgenerate

   always_comb begin
      count_in   = count_ff;
      newest_in  = newest_ff;
      status     = ST_OK;
      removed    = '0;
      retired_pc = '0;
      if (start) begin
         unique case (req_opcode)
            OP_INSERT: begin
               newest_in = req_branch_tag;
               if (full) begin
                  status = ST_FULL;
               end else begin
                  count_in = count_ff + CNT_W'(1);
               end
            end
            OP_RETIRE: begin
               if (req_is_control_flow) begin
                  if (head_hit) begin
                     retired_pc = pc_pad[0];
                     removed    = CNT_W'(1);
                     count_in   = count_ff - CNT_W'(1);
                  end else begin
                     status = ST_MISMATCH;
                  end
               end
            end
            OP_FLUSH: begin
               count_in = flush_cnt;
               removed  = count_ff - flush_cnt;
               if (flush_cnt == '0) begin
                  status = ST_NOT_FOUND;
               end
            end
            OP_UNUSED: begin
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         newest_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         newest_ff    <= newest_in;
         rsp_valid_ff <= start;
      end
      status_ff  <= status;
      removed_ff <= OUT_CNT_W'(removed);
      retired_ff <= retired_pc;
      occ_ff     <= OUT_CNT_W'(count_in);
      full_ff    <= (count_in == CNT_W'(QUEUE_DEPTH));
      latest_ff  <= newest_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = status_ff;
   assign rsp_removed_count = removed_ff;
   assign rsp_retired_pc    = retired_ff;
   assign rsp_occupancy     = occ_ff;
   assign rsp_queue_full    = full_ff;
   assign rsp_latest_tag    = latest_ff;

endmodule

`default_nettype wire
